// ===== rtl/core/als_pkg.sv =====
package als_pkg;

    localparam int CAPACITY   = 16;
    localparam int WORD_WIDTH = 32;

    localparam int ELEM_W = 32;
    localparam int POS_W  = 4;
    localparam int REQ_W  = 3;
    localparam int STAT_W = 2;

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // s_tdata: elem_value, position; m_tdata: read_value, status, count, is_empty, is_full
    localparam int S_DATA_BITS = ELEM_W + POS_W;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ELEM_W + STAT_W + CNT_W + 2;
    localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_BACK   = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_READ_AT    = 3'd4,
        REQ_READ_FRONT = 3'd5,
        REQ_READ_BACK  = 3'd6
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } als_cmd_t;

    typedef struct packed {
        logic out_free;
    } als_stat_t;

    // ring slot of list index idx, idx below CAPACITY
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] front,
                                                   input logic [SLOT_W-1:0] idx);
        logic [SLOT_W:0] sum;
        sum = {1'b0, front} + {1'b0, idx};
        if (sum >= (SLOT_W + 1)'(CAPACITY)) begin
            sum = sum - (SLOT_W + 1)'(CAPACITY);
        end
        return sum[SLOT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/als_ram.sv =====
module als_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                   wr_data,
    input  logic                               rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                   rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/als_dp.sv =====
module als_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  als_pkg::als_cmd_t            cmd,
    output als_pkg::als_stat_t           stat,
    input  logic [als_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [als_pkg::REQ_W-1:0]    s_tuser,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [als_pkg::M_DATA_W-1:0] m_tdata
);

    import als_pkg::*;

    // captured request
    req_t               req_reg;
    logic [ELEM_W-1:0]  val_reg;
    logic [POS_W-1:0]   pos_reg;

    // list state
    logic [SLOT_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // result of the access step
    status_t            pend_status_reg, pend_status_next;
    logic               pend_rd_ok_reg, pend_rd_ok_next;

    // output register
    logic               out_valid_reg;
    logic [ELEM_W-1:0]  out_value_reg;
    status_t            out_status_reg;
    logic [CNT_W-1:0]   out_count_reg;
    logic               out_empty_reg;
    logic               out_full_reg;

    logic               wr_en, rd_en;
    logic [SLOT_W-1:0]  wr_addr, rd_addr;
    logic [WORD_WIDTH-1:0] rd_data;
    logic               is_empty, is_full;
    logic [CMP_W-1:0]   pos_ext, cnt_ext;
    logic [SLOT_W-1:0]  front_inc, front_dec;

    als_ram #(
        .WIDTH(WORD_WIDTH),
        .DEPTH(CAPACITY)
    ) u_store (
        .clk    (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(WORD_WIDTH'(val_reg)),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign pos_ext   = CMP_W'(pos_reg);
    assign cnt_ext   = CMP_W'(count_reg);
    assign front_inc = (front_reg == SLOT_W'(CAPACITY - 1)) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? SLOT_W'(CAPACITY - 1) : front_reg - 1'b1;

    always_comb begin
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        wr_addr          = front_reg;
        rd_addr          = front_reg;
        front_next       = front_reg;
        count_next       = count_reg;
        pend_status_next = ST_OK;
        pend_rd_ok_next  = 1'b0;
        case (req_reg)
            REQ_PUSH_BACK: begin
                if (is_full) begin
                    pend_status_next = ST_FULL;
                end else begin
                    wr_en      = cmd.exec;
                    wr_addr    = slot_add(front_reg, SLOT_W'(count_reg));
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_PUSH_FRONT: begin
                if (is_full) begin
                    pend_status_next = ST_FULL;
                end else begin
                    wr_en      = cmd.exec;
                    wr_addr    = front_dec;
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_POP_BACK: begin
                if (is_empty) begin
                    pend_status_next = ST_EMPTY;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (is_empty) begin
                    pend_status_next = ST_EMPTY;
                end else begin
                    front_next = front_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            REQ_READ_AT: begin
                if (is_empty) begin
                    pend_status_next = ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    pend_status_next = ST_RANGE;
                end else begin
                    rd_en           = cmd.exec;
                    rd_addr         = slot_add(front_reg, SLOT_W'(pos_reg));
                    pend_rd_ok_next = 1'b1;
                end
            end
            REQ_READ_FRONT: begin
                if (is_empty) begin
                    pend_status_next = ST_EMPTY;
                end else begin
                    rd_en           = cmd.exec;
                    pend_rd_ok_next = 1'b1;
                end
            end
            REQ_READ_BACK: begin
                if (is_empty) begin
                    pend_status_next = ST_EMPTY;
                end else begin
                    rd_en           = cmd.exec;
                    rd_addr         = slot_add(front_reg, SLOT_W'(count_reg - 1'b1));
                    pend_rd_ok_next = 1'b1;
                end
            end
            default: begin
                // unused request code: no change, ok status
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= req_t'(s_tuser);
            val_reg <= s_tdata[ELEM_W-1:0];
            pos_reg <= s_tdata[ELEM_W +: POS_W];
        end
        if (cmd.exec) begin
            pend_status_reg <= pend_status_next;
            pend_rd_ok_reg  <= pend_rd_ok_next;
        end
        if (cmd.load_out) begin
            out_value_reg  <= pend_rd_ok_reg ? ELEM_W'(rd_data) : '0;
            out_status_reg <= pend_status_reg;
            out_count_reg  <= count_reg;
            out_empty_reg  <= is_empty;
            out_full_reg   <= is_full;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = M_DATA_W'({out_full_reg, out_empty_reg, out_count_reg,
                                      out_status_reg, out_value_reg});

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("word count above capacity");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> (count_reg == $past(count_reg)) ||
                     (count_reg == $past(count_reg) + 1'b1) ||
                     (count_reg == $past(count_reg) - 1'b1))
        else $error("count moved by more than one word");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before it was taken");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg == ST_FULL) |-> out_full_reg)
        else $error("full status on a list that is not full");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg == ST_EMPTY) |-> out_empty_reg)
        else $error("empty status on a list that is not empty");

endmodule

// ===== rtl/core/als_ctrl.sv =====
module als_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  als_pkg::als_stat_t  stat,
    output als_pkg::als_cmd_t   cmd
);

    import als_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
            end
            S_RESULT: begin
                cmd.load_out = stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/core/array_list_store.sv =====
// ordered list of up to CAPACITY words kept in a ring buffer
//
// input channel (s_): one request item per handshake; s_tuser carries the
// request kind (push back/front, pop back/front, read at/front/back),
// s_tdata the word to push and the list position for read at.
// result channel (m_): exactly one result item per request, in order, with
// the word read (zero unless a read succeeds), a status code, and the count
// and empty/full flags as they stand after the request.
//
// one request is worked at a time: capture, one ring buffer access (read or
// write of the word store), then result load, so a new item is taken only
// after the result of the last one has been loaded into the output register.
// the output register lets the next request be accepted while a result
// still waits; if the receiver stalls, the following result holds in its
// final step until the output register drains.
// reset clears the list (count and front slot) and the output valid; the
// word store itself is not cleared, only live entries are ever read.
module array_list_store (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [als_pkg::S_DATA_W-1:0] s_tdata,  // elem_value, position, zero pad
    input  logic [als_pkg::REQ_W-1:0]    s_tuser,  // req_type
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [als_pkg::M_DATA_W-1:0] m_tdata   // read_value, status, count, is_empty,
                                                   // is_full, zero pad
);

    import als_pkg::*;

    als_cmd_t  cmd;
    als_stat_t stat;

    als_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    als_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tready(m_tready),
        .m_tvalid(m_tvalid),
        .m_tdata (m_tdata)
    );

endmodule

// ===== tb/array_list_store_test.sv =====
module array_list_store_test;
    timeunit 1ns;
    timeprecision 1ps;

    import als_pkg::*;

    localparam logic [REQ_W-1:0] REQ_NOP = 3'd7;  // unused code, block treats it as a no-op
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int IDLE_PCT     = 21;

    // m_tdata field offsets
    localparam int ST_LO  = ELEM_W;
    localparam int CNT_LO = ST_LO + STAT_W;
    localparam int EMP_AT = CNT_LO + CNT_W;
    localparam int FUL_AT = EMP_AT + 1;

    typedef struct {
        logic [ELEM_W-1:0] read_value;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
        logic              is_empty;
        logic              is_full;
    } list_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [REQ_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    // shadow copy of the list
    logic [WORD_WIDTH-1:0] list_words [CAPACITY];
    logic [SLOT_W-1:0]     list_front = '0;
    logic [CNT_W-1:0]      list_count = '0;

    list_result_t          pending_results [$];
    int                    mismatches = 0;
    int                    cycle_count = 0;
    bit                    no_gaps = 1'b0;

    array_list_store dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int ring_slot(int idx);
        return (int'(list_front) + idx) % CAPACITY;
    endfunction

    function automatic list_result_t predict_request(logic [REQ_W-1:0] req,
                                                     logic [ELEM_W-1:0] val,
                                                     logic [POS_W-1:0] pos);
        list_result_t r;
        r.read_value = '0;
        r.status = ST_OK;
        case (req)
            REQ_PUSH_BACK: begin
                if (list_count == CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    list_words[ring_slot(int'(list_count))] = val[WORD_WIDTH-1:0];
                    list_count = list_count + 1'b1;
                end
            end
            REQ_PUSH_FRONT: begin
                if (list_count == CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    list_front = SLOT_W'((int'(list_front) + CAPACITY - 1) % CAPACITY);
                    list_words[list_front] = val[WORD_WIDTH-1:0];
                    list_count = list_count + 1'b1;
                end
            end
            REQ_POP_BACK: begin
                if (list_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    list_count = list_count - 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (list_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    list_front = SLOT_W'(ring_slot(1));
                    list_count = list_count - 1'b1;
                end
            end
            REQ_READ_AT: begin
                if (list_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (int'(pos) >= int'(list_count)) begin
                    r.status = ST_RANGE;
                end else begin
                    r.read_value = ELEM_W'(list_words[ring_slot(int'(pos))]);
                end
            end
            REQ_READ_FRONT: begin
                if (list_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_value = ELEM_W'(list_words[ring_slot(0)]);
                end
            end
            REQ_READ_BACK: begin
                if (list_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_value = ELEM_W'(list_words[ring_slot(int'(list_count) - 1)]);
                end
            end
            default: begin
            end
        endcase
        r.count = list_count;
        r.is_empty = (list_count == 0);
        r.is_full = (list_count == CAPACITY);
        return r;
    endfunction

    task automatic send_request(logic [REQ_W-1:0] req, logic [ELEM_W-1:0] val,
                                logic [POS_W-1:0] pos);
        list_result_t expected;
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= S_DATA_W'({pos, val});
        do begin
            @(posedge aclk);
        end while (!s_tready);
        expected = predict_request(req, val, pos);
        pending_results = {pending_results, expected};
    endtask

    function automatic void check_result(logic [M_DATA_W-1:0] data);
        list_result_t want;
        list_result_t got;
        got.read_value = data[ELEM_W-1:0];
        got.status = data[CNT_LO-1:ST_LO];
        got.count = data[EMP_AT-1:CNT_LO];
        got.is_empty = data[EMP_AT];
        got.is_full = data[FUL_AT];
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result item: value %h status %0d count %0d",
                         got.read_value, got.status, got.count);
            end
            return;
        end
        want = pending_results[0];
        pending_results.delete(0);
        if (got.read_value !== want.read_value || got.status !== want.status ||
            got.count !== want.count || got.is_empty !== want.is_empty ||
            got.is_full !== want.is_full) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result item wrong: value %h/%h status %0d/%0d count %0d/%0d",
                         want.read_value, got.read_value, want.status, got.status,
                         want.count, got.count);
                $display("  empty %0b/%0b full %0b/%0b (expected/actual)",
                         want.is_empty, got.is_empty, want.is_full, got.is_full);
            end
        end
    endfunction

    // result side: check on handshake, then stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            check_result(m_tdata);
        end
        m_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic test_empty_list();
        send_request(REQ_POP_BACK, 32'hFFFF_FFFF, 4'hF);
        send_request(REQ_POP_FRONT, $urandom, 4'h0);
        send_request(REQ_READ_AT, $urandom, 4'h0);
        send_request(REQ_READ_FRONT, $urandom, 4'h5);
        send_request(REQ_READ_BACK, $urandom, 4'hA);
        send_request(REQ_NOP, 32'hFFFF_FFFF, 4'hF);
    endtask

    task automatic test_fill_to_full();
        logic [ELEM_W-1:0] val;
        send_request(REQ_PUSH_BACK, 32'h0000_0000, 4'hF);
        // one word held, so index 15 is out of range
        send_request(REQ_READ_AT, $urandom, 4'hF);
        for (int i = 0; i < CAPACITY - 1; i++) begin
            case (i % 4)
                0: val = 32'hFFFF_FFFF;
                1: val = 32'hA5A5_5A5A;
                2: val = 32'h0000_0001;
                default: val = $urandom;
            endcase
            send_request(i[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK, val, 4'($urandom));
        end
    endtask

    task automatic test_full_list();
        send_request(REQ_PUSH_BACK, 32'hDEAD_0001, 4'h0);
        send_request(REQ_PUSH_FRONT, 32'hDEAD_0002, 4'h0);
        send_request(REQ_READ_AT, $urandom, 4'hF);
        send_request(REQ_READ_FRONT, $urandom, 4'h0);
        send_request(REQ_READ_BACK, $urandom, 4'h0);
    endtask

    task automatic test_random_traffic();
        int                mode;
        int                roll;
        logic [REQ_W-1:0]  req;
        logic [ELEM_W-1:0] val;
        logic [POS_W-1:0]  pos;
        mode = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // bursts lean toward filling, draining or mixed traffic
            if (n % 24 == 0) begin
                mode = $urandom_range(0, 2);
            end
            no_gaps = (n >= 450 && n < 750);
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                req = REQ_NOP;
            end else if (roll < (mode == 0 ? 55 : mode == 1 ? 20 : 36)) begin
                req = roll[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
            end else if (roll < (mode == 2 ? 70 : 72)) begin
                req = roll[0] ? REQ_POP_FRONT : REQ_POP_BACK;
            end else begin
                case ($urandom_range(0, 3))
                    0: req = REQ_READ_FRONT;
                    1: req = REQ_READ_BACK;
                    default: req = REQ_READ_AT;
                endcase
            end
            case ($urandom_range(0, 9))
                0: val = '0;
                1: val = '1;
                default: val = $urandom;
            endcase
            if (list_count != 0 && $urandom_range(0, 99) < 80) begin
                pos = POS_W'($urandom_range(0, int'(list_count) - 1));
            end else begin
                pos = POS_W'($urandom);
            end
            send_request(req, val, pos);
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_list();
        test_fill_to_full();
        test_full_list();
        test_random_traffic();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("array_list_store: match");
        end else begin
            $display("array_list_store: mismatch");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout waiting for result items");
        $display("array_list_store: mismatch");
        $finish;
    end

endmodule
